// ===== sv/id3_pkg.sv =====
// ----------------------------------------------------------------------------
// id3_pkg
// Shared types and constants of the ID3v2.3 frame deframer.
// ----------------------------------------------------------------------------
package id3_pkg;

  localparam int unsigned HDR_LEN   = 10;
  localparam int unsigned HDR_CNT_W = $clog2(HDR_LEN);
  localparam int unsigned TAG_LEN_W = 28;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    KIND_HDR   = 3'd0,
    KIND_DATA  = 3'd1,
    KIND_BADID = 3'd2,
    KIND_BIG   = 3'd3,
    KIND_END   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_CONTENT = 2'd1,
    PH_SKIP    = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  // One queue entry: a result, plus a flag that a tag-ended result follows it.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] frame_id;
    logic [31:0] frame_size;
    logic [15:0] frame_flags;
    logic [7:0]  content_byte;
    logic        last_of_frame;
    logic        add_end;
  } entry_t;

endpackage

// ===== sv/id3_if.sv =====
// ----------------------------------------------------------------------------
// id3_in_if / id3_out_if
// Valid/ready channels for tag body bytes and for parse results.
// ----------------------------------------------------------------------------
interface id3_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface id3_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] frame_id;
  logic [31:0] frame_size;
  logic [15:0] frame_flags;
  logic [7:0]  content_byte;
  logic        last_of_frame;

  modport source (output valid, output kind, output frame_id, output frame_size,
                  output frame_flags, output content_byte, output last_of_frame,
                  input ready);
  modport sink   (input valid, input kind, input frame_id, input frame_size,
                  input frame_flags, input content_byte, input last_of_frame,
                  output ready);
endinterface

// ===== sv/id3_front.sv =====
// ----------------------------------------------------------------------------
// id3_front
// Byte parser: collects frame headers, tracks tag and content counts, and
// queues one entry for each byte that causes a result.
// ----------------------------------------------------------------------------
module id3_front import id3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [TAG_LEN_W-1:0] cfg_wdata,
  id3_in_if.sink               in_ch,
  input  logic                 full,
  output logic                 push,
  output entry_t               push_data
);

  phase_t                 phase_r, phase_nxt;
  logic [HDR_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TAG_LEN_W-1:0]   rem_r, rem_nxt;
  logic [31:0]            crem_r, crem_nxt;
  logic [71:0]            hdr_r, hdr_nxt;

  logic                   fire;
  logic [7:0]             b;
  logic [79:0]            hdr_full;
  logic [31:0]            hid, hsize, crem_dec;
  logic [15:0]            hflags;
  logic [TAG_LEN_W-1:0]   rem_dec;
  logic                   id_ok;

  function automatic logic id_char_ok(input logic [7:0] c);
    id_char_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  assign in_ch.ready = !full;
  assign fire        = in_ch.valid && !full;
  assign b           = in_ch.data_byte;
  assign hdr_full    = {hdr_r, b};
  assign hid         = hdr_full[79:48];
  assign hsize       = hdr_full[47:16];
  assign hflags      = hdr_full[15:0];
  assign rem_dec     = rem_r - TAG_LEN_W'(1);
  assign crem_dec    = crem_r - 32'd1;
  assign id_ok       = id_char_ok(hid[31:24]) && id_char_ok(hid[23:16]) &&
                       id_char_ok(hid[15:8])  && id_char_ok(hid[7:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DONE;
      cnt_r   <= '0;
      rem_r   <= '0;
      crem_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      crem_r  <= crem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    crem_nxt  = crem_r;
    hdr_nxt   = hdr_r;
    push      = 1'b0;
    push_data = '0;
    push_data.kind = KIND_END;

    if (cfg_we) begin
      rem_nxt   = cfg_wdata;
      cnt_nxt   = '0;
      crem_nxt  = '0;
      phase_nxt = (cfg_wdata == '0) ? PH_DONE : PH_HEADER;
    end else if (fire) begin
      case (phase_r)
        PH_SKIP: begin
          if (rem_r != '0) begin
            rem_nxt = rem_dec;
          end
          if (rem_r == '0 || rem_dec == '0) begin
            phase_nxt = PH_DONE;
          end
        end
        PH_CONTENT: begin
          rem_nxt  = rem_dec;
          crem_nxt = crem_dec;
          push     = 1'b1;
          push_data.kind          = KIND_DATA;
          push_data.content_byte  = b;
          push_data.last_of_frame = (crem_dec == '0);
          push_data.add_end       = (rem_dec == '0);
          if (rem_dec == '0) begin
            phase_nxt = PH_DONE;
          end else if (crem_dec == '0) begin
            phase_nxt = PH_HEADER;
          end
        end
        PH_HEADER: begin
          rem_nxt = rem_dec;
          if (cnt_r == '0 && rem_r < TAG_LEN_W'(HDR_LEN)) begin
            // Too few bytes left for a header: report the end and skip.
            push      = 1'b1;
            phase_nxt = (rem_dec == '0) ? PH_DONE : PH_SKIP;
          end else if (cnt_r != HDR_CNT_W'(HDR_LEN - 1)) begin
            hdr_nxt = hdr_full[71:0];
            cnt_nxt = cnt_r + HDR_CNT_W'(1);
          end else begin
            cnt_nxt = '0;
            push    = 1'b1;
            push_data.frame_id    = hid;
            push_data.frame_size  = hsize;
            push_data.frame_flags = hflags;
            if (!id_ok) begin
              push_data.kind = KIND_BADID;
              phase_nxt      = (rem_dec == '0) ? PH_DONE : PH_SKIP;
            end else if (hsize > {{(32-TAG_LEN_W){1'b0}}, rem_dec}) begin
              push_data.kind = KIND_BIG;
              phase_nxt      = (rem_dec == '0) ? PH_DONE : PH_SKIP;
            end else if (hsize == '0) begin
              push_data.kind          = KIND_HDR;
              push_data.last_of_frame = 1'b1;
              push_data.add_end       = (rem_dec == '0);
              phase_nxt               = (rem_dec == '0) ? PH_DONE : PH_HEADER;
            end else begin
              push_data.kind = KIND_HDR;
              crem_nxt       = hsize;
              phase_nxt      = PH_CONTENT;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/id3_fifo.sv =====
// ----------------------------------------------------------------------------
// id3_fifo
// Short register queue of result entries between parser and output stage.
// ----------------------------------------------------------------------------
module id3_fifo import id3_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t head,
  output logic   empty,
  output logic   full
);

  entry_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == QCNT_W'(QDEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + QCNT_W'(1)))
    else $error("queue count did not follow a lone write");

endmodule

// ===== sv/id3_back.sv =====
// ----------------------------------------------------------------------------
// id3_back
// Output stage: presents the queue head and, where flagged, a tag-ended
// result after it before releasing the entry.
// ----------------------------------------------------------------------------
module id3_back import id3_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  entry_t    head,
  input  logic      empty,
  output logic      pop,
  id3_out_if.source out_ch
);

  logic second_r, second_nxt;
  logic xfer;

  assign out_ch.valid = !empty;
  assign xfer         = !empty && out_ch.ready;

  always_comb begin
    if (second_r) begin
      out_ch.kind          = KIND_END;
      out_ch.frame_id      = '0;
      out_ch.frame_size    = '0;
      out_ch.frame_flags   = '0;
      out_ch.content_byte  = '0;
      out_ch.last_of_frame = 1'b0;
    end else begin
      out_ch.kind          = head.kind;
      out_ch.frame_id      = head.frame_id;
      out_ch.frame_size    = head.frame_size;
      out_ch.frame_flags   = head.frame_flags;
      out_ch.content_byte  = head.content_byte;
      out_ch.last_of_frame = head.last_of_frame;
    end
    pop        = xfer && (second_r || !head.add_end);
    second_nxt = xfer ? (!second_r && head.add_end) : second_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
    end else begin
      second_r <= second_nxt;
    end
  end

endmodule

// ===== sv/id3v23_frame_deframer_top.sv =====
// A result is stored in the queue at its byte transfer and offered on out_ch
// from the head. One byte per cycle while the queue is not full; a byte that
// ends the tag exactly gives two results, absorbed by the 4-entry queue.
// Reset (rst_n low, synchronous) leaves the parser in its done state and the
// queue empty; bytes give no result until tag_length is written.
// ----------------------------------------------------------------------------
// id3v23_frame_deframer_top
// ID3v2.3 frame header parser and content pass-through.
// ----------------------------------------------------------------------------
module id3v23_frame_deframer_top import id3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [TAG_LEN_W-1:0] cfg_wdata,
  id3_in_if.sink               in_ch,
  id3_out_if.source            out_ch
);

  entry_t push_data, head;
  logic   push, pop, empty, full;

  id3_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  id3_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  id3_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ===== verif/id3v23_frame_deframer_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// id3v23_frame_deframer_top_test
// Drives ID3v2.3 tag bodies built from random frames, error tails and stray
// bytes into the deframer, predicts every header, error, content and end result
// and compares them in order with what the block delivers under random stalls.
// ----------------------------------------------------------------------------
module id3v23_frame_deframer_top_test;
  import id3_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] frame_id;
    logic [31:0] frame_size;
    logic [15:0] frame_flags;
    logic [7:0]  content_byte;
    logic        last_of_frame;
  } frame_result_t;

  class frame_scoreboard;
    phase_t                 phase;
    logic [7:0]             hdr [HDR_LEN];
    int unsigned            hdr_cnt;
    logic [TAG_LEN_W-1:0]   tag_left;
    logic [31:0]            content_left;
    frame_result_t          awaited [$];
    int unsigned            errors;

    function new();
      phase = PH_DONE;
      foreach (hdr[i]) hdr[i] = 8'h00;
      hdr_cnt = 0;
      tag_left = '0;
      content_left = '0;
      errors = 0;
    endfunction

    static function bit is_id_char(logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function void write_tag_length(logic [TAG_LEN_W-1:0] v);
      foreach (hdr[i]) hdr[i] = 8'h00;
      hdr_cnt = 0;
      content_left = '0;
      tag_left = v;
      phase = (v == 0) ? PH_DONE : PH_HEADER;
    endfunction

    function void push_awaited(kind_t k, logic [31:0] id, logic [31:0] size,
                               logic [15:0] flags, logic [7:0] cb, logic last);
      frame_result_t r;
      r.kind = k;
      r.frame_id = id;
      r.frame_size = size;
      r.frame_flags = flags;
      r.content_byte = cb;
      r.last_of_frame = last;
      awaited.push_back(r);
    endfunction

    // Called for every byte transfer on the input channel.
    function void note_byte(logic [7:0] b);
      logic [31:0] id;
      logic [31:0] size;
      logic [15:0] flags;
      bit          id_ok;
      id = '0;
      size = '0;
      id_ok = 1'b1;
      case (phase)
        PH_DONE: ;
        PH_SKIP: begin
          if (tag_left != 0) tag_left--;
          if (tag_left == 0) phase = PH_DONE;
        end
        PH_CONTENT: begin
          content_left--;
          tag_left--;
          push_awaited(KIND_DATA, '0, '0, '0, b, content_left == 0);
          if (content_left == 0) phase = PH_HEADER;
          if (tag_left == 0) begin
            push_awaited(KIND_END, '0, '0, '0, '0, 1'b0);
            phase = PH_DONE;
          end
        end
        PH_HEADER: begin
          if (hdr_cnt == 0 && tag_left < HDR_LEN) begin
            // Too little left for a header: report the end once, skip the rest.
            push_awaited(KIND_END, '0, '0, '0, '0, 1'b0);
            tag_left--;
            phase = (tag_left == 0) ? PH_DONE : PH_SKIP;
          end else begin
            hdr[hdr_cnt] = b;
            hdr_cnt++;
            tag_left--;
            if (hdr_cnt == HDR_LEN) begin
              hdr_cnt = 0;
              for (int i = 0; i < 4; i++) begin
                id = {id[23:0], hdr[i]};
                if (!is_id_char(hdr[i])) id_ok = 1'b0;
              end
              size = {hdr[4], hdr[5], hdr[6], hdr[7]};
              flags = {hdr[8], hdr[9]};
              if (!id_ok) begin
                push_awaited(KIND_BADID, id, size, flags, '0, 1'b0);
                phase = (tag_left == 0) ? PH_DONE : PH_SKIP;
              end else if (size > tag_left) begin
                push_awaited(KIND_BIG, id, size, flags, '0, 1'b0);
                phase = (tag_left == 0) ? PH_DONE : PH_SKIP;
              end else begin
                push_awaited(KIND_HDR, id, size, flags, '0, size == 0);
                if (size == 0) begin
                  if (tag_left == 0) begin
                    push_awaited(KIND_END, '0, '0, '0, '0, 1'b0);
                    phase = PH_DONE;
                  end
                end else begin
                  content_left = size;
                  phase = PH_CONTENT;
                end
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      bit            ok;
      if (awaited.size() == 0) begin
        $error("result with none awaited: kind %0d", got.kind);
        errors++;
        return;
      end
      want = awaited.pop_front();
      ok = field_ok("kind", want.kind, got.kind);
      ok = field_ok("frame_id", want.frame_id, got.frame_id) && ok;
      ok = field_ok("frame_size", want.frame_size, got.frame_size) && ok;
      ok = field_ok("frame_flags", want.frame_flags, got.frame_flags) && ok;
      ok = field_ok("content_byte", want.content_byte, got.content_byte) && ok;
      ok = field_ok("last_of_frame", want.last_of_frame, got.last_of_frame) && ok;
      if (!ok) errors++;
    endfunction

    function void flag_leftovers();
      frame_result_t r;
      while (awaited.size() != 0) begin
        r = awaited.pop_front();
        $error("result never delivered: kind %0d", r.kind);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [TAG_LEN_W-1:0] cfg_wdata;
  bit                   in_idle;
  bit                   out_idle;
  int unsigned          tag_items;
  frame_scoreboard      sb = new();

  id3_in_if  in_ch();
  id3_out_if out_ch();

  id3v23_frame_deframer_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAIL id3v23_frame_deframer_top");
    $finish;
  end

  // Result side: random stall before each transfer while out_idle is set, then check it.
  initial begin : result_sink
    int            stall;
    bit            seen;
    frame_result_t got;
    out_ch.ready = 1'b0;
    forever begin
      stall = out_idle ? $urandom_range(0, 14) : 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      seen = 1'b0;
      while (!seen) begin
        @(negedge clk);
        seen = (out_ch.valid === 1'b1);
        got.kind = kind_t'(out_ch.kind);
        got.frame_id = out_ch.frame_id;
        got.frame_size = out_ch.frame_size;
        got.frame_flags = out_ch.frame_flags;
        got.content_byte = out_ch.content_byte;
        got.last_of_frame = out_ch.last_of_frame;
        @(posedge clk);
      end
      sb.check_result(got);
    end
  end

  // Ready is sampled at the falling edge so the transfer decision at the
  // next rising edge does not race with the block's own updates.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    bit taken;
    gap = in_idle ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = (in_ch.ready === 1'b1);
      @(posedge clk);
    end
    sb.note_byte(b);
  endtask

  task automatic send_tag_bytes(ref logic [7:0] q[$]);
    foreach (q[i]) begin
      send_byte(q[i]);
      tag_items++;
    end
  endtask

  task automatic send_stray_bytes(input int n);
    repeat (n) send_byte(8'($urandom));
  endtask

  // Loads the register only once the block has drained.
  task automatic load_tag_length(input logic [TAG_LEN_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_tag_length(v);
  endtask

  function automatic logic [7:0] pick_id_char();
    int n;
    n = $urandom_range(0, 35);
    return (n < 10) ? 8'(8'h30 + n) : 8'(8'h41 + n - 10);
  endfunction

  function automatic logic [7:0] pick_bad_char();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0: c = 8'h2F;
      1: c = 8'h3A;
      2: c = 8'h40;
      3: c = 8'h5B;
      4: c = 8'(8'h61 + $urandom_range(0, 25));
      default: begin
        c = 8'($urandom);
        while (frame_scoreboard::is_id_char(c)) c = 8'($urandom);
      end
    endcase
    return c;
  endfunction

  function automatic logic [31:0] pick_id(bit bad);
    logic [31:0] id;
    int          pos;
    for (int i = 0; i < 4; i++) id = {id[23:0], pick_id_char()};
    if (bad) begin
      pos = $urandom_range(0, 3);
      id[pos*8 +: 8] = pick_bad_char();
    end
    return id;
  endfunction

  function automatic void add_header(ref logic [7:0] q[$], input logic [31:0] id,
                                     input logic [31:0] size, input logic [15:0] flags);
    for (int i = 3; i >= 0; i--) q.push_back(id[i*8 +: 8]);
    for (int i = 3; i >= 0; i--) q.push_back(size[i*8 +: 8]);
    q.push_back(flags[15:8]);
    q.push_back(flags[7:0]);
  endfunction

  function automatic void add_random_bytes(ref logic [7:0] q[$], input int n);
    repeat (n) q.push_back(8'($urandom));
  endfunction

  task automatic run_random_tag();
    logic [7:0]           body [$];
    logic [TAG_LEN_W-1:0] len;
    logic [31:0]          size;
    int                   k;
    int                   sel;
    int                   cut;
    in_idle = ($urandom_range(0, 3) != 0);
    out_idle = ($urandom_range(0, 3) != 0);
    repeat ($urandom_range(0, 4)) begin
      sel = $urandom_range(0, 9);
      size = (sel < 3) ? 0 : (sel < 9) ? $urandom_range(1, 16) : $urandom_range(17, 64);
      add_header(body, pick_id(1'b0), size, 16'($urandom));
      add_random_bytes(body, size);
    end
    case ($urandom_range(0, 5))
      1: add_random_bytes(body, $urandom_range(1, 9));
      2: begin
        add_header(body, pick_id(1'b1), $urandom, 16'($urandom));
        add_random_bytes(body, $urandom_range(0, 6));
      end
      3: begin
        // Frame claims more bytes than the tag has left after its header.
        k = $urandom_range(0, 6);
        case ($urandom_range(0, 2))
          0: size = k + 1 + $urandom_range(0, 2);
          1: size = 32'hFFFF_FFFF;
          default: size = {1'b1, 31'($urandom)};
        endcase
        add_header(body, pick_id(1'b0), size, 16'($urandom));
        add_random_bytes(body, k);
      end
      4: repeat ($urandom_range(10, 14)) body.push_back(8'h00);
      default: ;
    endcase
    len = TAG_LEN_W'(body.size());
    sel = $urandom_range(0, 19);
    if (sel == 0) len = '0;
    else if (sel < 3) len = '1;
    else if (sel < 5) begin
      cut = $urandom_range(0, body.size());
      while (body.size() > cut) void'(body.pop_back());
    end
    load_tag_length(len);
    send_tag_bytes(body);
    if (sel >= 5) send_stray_bytes($urandom_range(0, 3));
  endtask

  initial begin : stimulus
    logic [7:0] body [$];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_idle = 1'b1;
    out_idle = 1'b1;
    tag_items = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Nothing is reported before the first register write.
    send_stray_bytes(2);
    load_tag_length('0);
    send_stray_bytes(1);
    load_tag_length(TAG_LEN_W'(1));
    body = '{8'hFF};
    send_tag_bytes(body);
    // Zero-size frame that ends the tag exactly, with boundary ID characters.
    load_tag_length(TAG_LEN_W'(HDR_LEN));
    body.delete();
    add_header(body, {8'h30, 8'h39, 8'h41, 8'h5A}, 32'h0, 16'hFFFF);
    send_tag_bytes(body);
    in_idle = 1'b0;
    out_idle = 1'b0;
    load_tag_length(TAG_LEN_W'(HDR_LEN + 3));
    body.delete();
    add_header(body, 32'h5449_5432, 32'd3, 16'h8000);
    body.push_back(8'h00);
    body.push_back(8'hFF);
    body.push_back(8'h5A);
    send_tag_bytes(body);
    load_tag_length('1);

    while (tag_items < 1650) run_random_tag();

    in_ch.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("PASS id3v23_frame_deframer_top");
    end else begin
      $display("FAIL id3v23_frame_deframer_top");
    end
    $finish;
  end

endmodule
